// File: hw/rtl/alfl_pkg.sv
// ----------------------------------------------------------------------------
// alfl_pkg: shared types for the array linked list with free list
// Request and response layouts, action codes and status codes.
// ----------------------------------------------------------------------------
package alfl_pkg;

	typedef logic [2:0]  action_raw_t;
	typedef logic [15:0] key_field_t;
	typedef logic [31:0] data_field_t;
	typedef logic [1:0]  status_raw_t;
	typedef logic [5:0]  slot_field_t;
	typedef logic [6:0]  pos_field_t;
	typedef logic [6:0]  count_field_t;

	typedef enum logic [2:0] {
		ACT_INS_HEAD = 3'd0,
		ACT_INS_TAIL = 3'd1,
		ACT_FIND     = 3'd2,
		ACT_REMOVE   = 3'd3,
		ACT_CLEAR    = 3'd4,
		ACT_DUMP     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		action_raw_t action;
		key_field_t  key;
		data_field_t payload;
	} req_t;

	typedef struct packed {
		status_raw_t  status;
		slot_field_t  slot;
		key_field_t   entry_key;
		data_field_t  entry_payload;
		pos_field_t   position;
		count_field_t entry_count;
		logic         last;
	} rsp_t;

endpackage

// File: hw/rtl/alfl_store.sv
// ----------------------------------------------------------------------------
// alfl_store: slot storage for the linked list
// Link, key and data memories with one write and one registered read each.
// Links never written since the last clear read as the fresh free chain.
// ----------------------------------------------------------------------------
module alfl_store #(
	parameter int DEPTH     = 64,
	parameter int KEY_BITS  = 16,
	parameter int DATA_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clr,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	input  logic                         lnk_we,
	input  logic [$clog2(DEPTH)-1:0]     lnk_waddr,
	input  logic [$clog2(DEPTH+1)-1:0]   lnk_wdata,
	input  logic                         kd_we,
	input  logic [$clog2(DEPTH)-1:0]     kd_waddr,
	input  logic [KEY_BITS-1:0]          key_wdata,
	input  logic [DATA_BITS-1:0]         dat_wdata,
	output logic [$clog2(DEPTH+1)-1:0]   lnk_rdata,
	output logic [KEY_BITS-1:0]          key_rdata,
	output logic [DATA_BITS-1:0]         dat_rdata
);

	localparam int SLOT_W = $clog2(DEPTH);
	localparam int LINK_W = $clog2(DEPTH+1);

	logic [LINK_W-1:0]    lnk_mem [DEPTH];
	logic [KEY_BITS-1:0]  key_mem [DEPTH];
	logic [DATA_BITS-1:0] dat_mem [DEPTH];

	logic [DEPTH-1:0]  lv_q;
	logic              fresh_q;
	logic [SLOT_W-1:0] raddr_q;
	logic [LINK_W-1:0] lnk_raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q <= '0;
		end else if (clr) begin
			lv_q <= '0;
		end else if (lnk_we) begin
			lv_q[lnk_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (lnk_we) begin
			lnk_mem[lnk_waddr] <= lnk_wdata;
		end
		if (kd_we) begin
			key_mem[kd_waddr] <= key_wdata;
			dat_mem[kd_waddr] <= dat_wdata;
		end
		if (rd_en) begin
			lnk_raw_q <= lnk_mem[rd_addr];
			key_rdata <= key_mem[rd_addr];
			dat_rdata <= dat_mem[rd_addr];
			fresh_q   <= !lv_q[rd_addr];
			raddr_q   <= rd_addr;
		end
	end

	assign lnk_rdata = fresh_q ? (LINK_W'(raddr_q) + LINK_W'(1)) : lnk_raw_q;

endmodule

// File: hw/rtl/array_linked_list_with_free_list.sv
// ----------------------------------------------------------------------------
// array_linked_list_with_free_list: linked list in a slot array
// A small sequencer walks the list one slot read per cycle, unless a dump response stalls,
// to insert, find, remove or dump entries, or clears it; unused slots sit on a LIFO free chain.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Content
//  req      in         req_valid/req_ready  action, key, payload
//  rsp      out        rsp_valid/rsp_ready  status, slot, entry, position, count
//
// Insert at head, or at the tail of an empty list, passes TAKE and RESP; clear and
// rejected requests go straight to RESP. Tail insert, find and remove otherwise walk
// the list one linked-slot read per cycle through the single read port of the slot
// memories. Dump delivers one response per cycle. A request is taken only while the
// sequencer is idle, and a stalled response holds the sequencer in place. Reset is
// immediate: the free chain needs no clearing pass.
module array_linked_list_with_free_list #(
	parameter int DEPTH     = 64,
	parameter int KEY_BITS  = 16,
	parameter int DATA_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  alfl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output alfl_pkg::rsp_t rsp
);

	localparam int SLOT_W = $clog2(DEPTH);
	localparam int LINK_W = $clog2(DEPTH+1);
	localparam logic [LINK_W-1:0] NIL = LINK_W'(DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_TAKE   = 7'b0000010,
		ST_TAIL   = 7'b0000100,
		ST_WALK   = 7'b0001000,
		ST_UNLINK = 7'b0010000,
		ST_DUMP   = 7'b0100000,
		ST_RESP   = 7'b1000000
	} state_t;

	state_t                  state_q, state_d;
	alfl_pkg::action_raw_t   act_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [DATA_BITS-1:0]    dat_q;
	logic [LINK_W-1:0]       head_q, head_d;
	logic [LINK_W-1:0]       free_q, free_d;
	logic [LINK_W-1:0]       cnt_q, cnt_d;
	logic [SLOT_W-1:0]       cur_q, cur_d;
	logic [LINK_W-1:0]       prev_q, prev_d;
	logic [SLOT_W-1:0]       take_q, take_d;
	alfl_pkg::pos_field_t    pos_q, pos_d;
	alfl_pkg::status_t       res_st_q, res_st_d;
	logic [SLOT_W-1:0]       res_slot_q, res_slot_d;
	alfl_pkg::rsp_t          rsp_q, rsp_d;
	logic                    rsp_valid_q;
	logic                    emit;

	logic                    clr;
	logic                    rd_en;
	logic [SLOT_W-1:0]       rd_addr;
	logic                    lnk_we;
	logic [SLOT_W-1:0]       lnk_waddr;
	logic [LINK_W-1:0]       lnk_wdata;
	logic                    kd_we;
	logic [LINK_W-1:0]       lnk_rdata;
	logic [KEY_BITS-1:0]     key_rdata;
	logic [DATA_BITS-1:0]    dat_rdata;

	logic                    out_free;
	logic                    head_live;
	logic                    free_live;
	logic                    nx_live;
	logic                    prev_live;
	logic                    hit;
	logic                    accept;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign head_live = head_q < NIL;
	assign free_live = free_q < NIL;
	assign nx_live   = lnk_rdata < NIL;
	assign prev_live = prev_q < NIL;
	assign hit       = key_rdata == key_q;
	assign req_ready = state_q == ST_IDLE;
	assign accept    = req_valid && req_ready;

	alfl_store #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS),
		.DATA_BITS(DATA_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.lnk_we   (lnk_we),
		.lnk_waddr(lnk_waddr),
		.lnk_wdata(lnk_wdata),
		.kd_we    (kd_we),
		.kd_waddr (take_q),
		.key_wdata(key_q),
		.dat_wdata(dat_q),
		.lnk_rdata(lnk_rdata),
		.key_rdata(key_rdata),
		.dat_rdata(dat_rdata)
	);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		free_d     = free_q;
		cnt_d      = cnt_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		take_d     = take_q;
		pos_d      = pos_q;
		res_st_d   = res_st_q;
		res_slot_d = res_slot_q;
		clr        = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = cur_q;
		lnk_we     = 1'b0;
		lnk_waddr  = cur_q;
		lnk_wdata  = NIL;
		kd_we      = 1'b0;
		emit       = 1'b0;
		rsp_d      = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req.action) inside
						alfl_pkg::ACT_INS_HEAD, alfl_pkg::ACT_INS_TAIL: begin
							if (free_live) begin
								rd_en   = 1'b1;
								rd_addr = free_q[SLOT_W-1:0];
								take_d  = free_q[SLOT_W-1:0];
								state_d = ST_TAKE;
							end else begin
								res_st_d   = alfl_pkg::STAT_FULL;
								res_slot_d = '0;
								state_d    = ST_RESP;
							end
						end
						alfl_pkg::ACT_FIND, alfl_pkg::ACT_REMOVE: begin
							prev_d = NIL;
							if (head_live) begin
								rd_en   = 1'b1;
								rd_addr = head_q[SLOT_W-1:0];
								cur_d   = head_q[SLOT_W-1:0];
								state_d = ST_WALK;
							end else begin
								res_st_d   = alfl_pkg::STAT_NOT_FOUND;
								res_slot_d = '0;
								state_d    = ST_RESP;
							end
						end
						alfl_pkg::ACT_CLEAR: begin
							clr        = 1'b1;
							head_d     = NIL;
							free_d     = '0;
							cnt_d      = '0;
							res_st_d   = alfl_pkg::STAT_OK;
							res_slot_d = '0;
							state_d    = ST_RESP;
						end
						alfl_pkg::ACT_DUMP: begin
							if (head_live) begin
								rd_en   = 1'b1;
								rd_addr = head_q[SLOT_W-1:0];
								cur_d   = head_q[SLOT_W-1:0];
								pos_d   = alfl_pkg::pos_field_t'(1);
								state_d = ST_DUMP;
							end else begin
								res_st_d   = alfl_pkg::STAT_EMPTY;
								res_slot_d = '0;
								state_d    = ST_RESP;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_TAKE: begin
				kd_we     = 1'b1;
				free_d    = lnk_rdata;
				cnt_d     = cnt_q + LINK_W'(1);
				lnk_we    = 1'b1;
				lnk_waddr = take_q;
				if (act_q == alfl_pkg::ACT_INS_HEAD || !head_live) begin
					lnk_wdata  = (act_q == alfl_pkg::ACT_INS_HEAD) ? head_q : NIL;
					head_d     = LINK_W'(take_q);
					res_st_d   = alfl_pkg::STAT_OK;
					res_slot_d = take_q;
					state_d    = ST_RESP;
				end else begin
					lnk_wdata = NIL;
					rd_en     = 1'b1;
					rd_addr   = head_q[SLOT_W-1:0];
					cur_d     = head_q[SLOT_W-1:0];
					state_d   = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (nx_live) begin
					rd_en   = 1'b1;
					rd_addr = lnk_rdata[SLOT_W-1:0];
					cur_d   = lnk_rdata[SLOT_W-1:0];
				end else begin
					lnk_we     = 1'b1;
					lnk_waddr  = cur_q;
					lnk_wdata  = LINK_W'(take_q);
					res_st_d   = alfl_pkg::STAT_OK;
					res_slot_d = take_q;
					state_d    = ST_RESP;
				end
			end
			ST_WALK: begin
				if (hit) begin
					if (act_q == alfl_pkg::ACT_FIND) begin
						res_st_d   = alfl_pkg::STAT_OK;
						res_slot_d = cur_q;
						state_d    = ST_RESP;
					end else begin
						if (prev_live) begin
							lnk_we    = 1'b1;
							lnk_waddr = prev_q[SLOT_W-1:0];
							lnk_wdata = lnk_rdata;
						end else begin
							head_d = lnk_rdata;
						end
						state_d = ST_UNLINK;
					end
				end else if (nx_live) begin
					prev_d  = LINK_W'(cur_q);
					rd_en   = 1'b1;
					rd_addr = lnk_rdata[SLOT_W-1:0];
					cur_d   = lnk_rdata[SLOT_W-1:0];
				end else begin
					res_st_d   = alfl_pkg::STAT_NOT_FOUND;
					res_slot_d = '0;
					state_d    = ST_RESP;
				end
			end
			ST_UNLINK: begin
				lnk_we     = 1'b1;
				lnk_waddr  = cur_q;
				lnk_wdata  = free_q;
				free_d     = LINK_W'(cur_q);
				cnt_d      = cnt_q - LINK_W'(1);
				res_st_d   = alfl_pkg::STAT_OK;
				res_slot_d = cur_q;
				state_d    = ST_RESP;
			end
			ST_DUMP: begin
				if (out_free) begin
					emit                = 1'b1;
					rsp_d.status        = alfl_pkg::STAT_OK;
					rsp_d.slot          = alfl_pkg::slot_field_t'(cur_q);
					rsp_d.entry_key     = alfl_pkg::key_field_t'(key_rdata);
					rsp_d.entry_payload = alfl_pkg::data_field_t'(dat_rdata);
					rsp_d.position      = pos_q;
					rsp_d.entry_count   = alfl_pkg::count_field_t'(cnt_q);
					if (!nx_live || pos_q == alfl_pkg::pos_field_t'(DEPTH)) begin
						rsp_d.last = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						rsp_d.last = 1'b0;
						rd_en      = 1'b1;
						rd_addr    = lnk_rdata[SLOT_W-1:0];
						cur_d      = lnk_rdata[SLOT_W-1:0];
						pos_d      = pos_q + alfl_pkg::pos_field_t'(1);
					end
				end
			end
			ST_RESP: begin
				if (out_free) begin
					emit              = 1'b1;
					rsp_d.status      = res_st_q;
					rsp_d.slot        = alfl_pkg::slot_field_t'(res_slot_q);
					rsp_d.entry_count = alfl_pkg::count_field_t'(cnt_q);
					rsp_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= NIL;
			free_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			key_q <= KEY_BITS'(req.key);
			dat_q <= DATA_BITS'(req.payload);
		end
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		take_q     <= take_d;
		pos_q      <= pos_d;
		res_st_q   <= res_st_d;
		res_slot_q <= res_slot_d;
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hw/rtl/alfl_chk.sv
// ----------------------------------------------------------------------------
// alfl_chk: port checker for the array linked list with free list
// Watches the request and response channels and flags illegal sequences.
// ----------------------------------------------------------------------------
module alfl_chk #(
	parameter int DEPTH = 64
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input alfl_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input alfl_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Stalled response changed or dropped.");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.action <= alfl_pkg::ACT_DUMP |=> !req_ready)
		else $error("Block took a request while busy with the previous one.");

	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> !req_ready)
		else $error("Block idle while a dump is still in progress.");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != alfl_pkg::STAT_OK |->
			rsp.last && rsp.slot == '0 && rsp.position == '0)
		else $error("Error response is not a single final response with zero slot.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entry_count <= alfl_pkg::count_field_t'(DEPTH)
			&& rsp.position <= alfl_pkg::pos_field_t'(DEPTH))
		else $error("Entry count or position beyond the slot count.");

endmodule

bind array_linked_list_with_free_list alfl_chk #(
	.DEPTH(DEPTH)
) u_alfl_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
